FILE: hw/rtl/dmhc_pkg.sv
// ============================================================================
// dmhc_pkg
// Shared types and constants for the display mode history controller.
// ============================================================================
`default_nettype none

package dmhc_pkg;

  localparam int HIST_DEPTH  = 8;
  localparam int HIST_PTR_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int HIST_CNT_W  = $clog2(HIST_DEPTH + 1);
  localparam int COUNT_OUT_W = 4;

  localparam logic [HIST_PTR_W-1:0] PTR_LAST = HIST_PTR_W'(HIST_DEPTH - 1);
  localparam logic [HIST_CNT_W-1:0] CNT_FULL = HIST_CNT_W'(HIST_DEPTH);

  localparam logic [2:0] M_IDLE     = 3'd0;
  localparam logic [2:0] M_MENU     = 3'd1;
  localparam logic [2:0] M_APP      = 3'd2;
  localparam logic [2:0] M_NESTED   = 3'd3;
  localparam logic [2:0] M_LOWPOWER = 3'd4;
  localparam logic [2:0] M_OFF      = 3'd5;

  localparam logic [2:0] OP_TRANS    = 3'd0;
  localparam logic [2:0] OP_BACK     = 3'd1;
  localparam logic [2:0] OP_ACTIVITY = 3'd2;
  localparam logic [2:0] OP_CHECK    = 3'd3;
  localparam logic [2:0] OP_LOWPOWER = 3'd4;
  localparam logic [2:0] OP_WAKE     = 3'd5;
  localparam logic [2:0] OP_SHUTDOWN = 3'd6;

  localparam int CFG_ADDR_W = 4;

  localparam logic [1:0] REG_IDLE_LIMIT = 2'd0;
  localparam logic [1:0] REG_MENU_LIMIT = 2'd1;
  localparam logic [1:0] REG_APP_LIMIT  = 2'd2;

  localparam logic [31:0] IDLE_LIMIT_RST = 32'd30000;
  localparam logic [31:0] MENU_LIMIT_RST = 32'd60000;
  localparam logic [31:0] APP_LIMIT_RST  = 32'd120000;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] app;
  } hist_entry_t;

  typedef struct packed {
    logic                  rd_en;
    logic [HIST_PTR_W-1:0] rd_addr;
    logic                  wr_en;
    logic [HIST_PTR_W-1:0] wr_addr;
    hist_entry_t           wr_data;
  } hist_req_t;

  typedef struct packed {
    logic [31:0] idle_ms;
    logic [31:0] menu_ms;
    logic [31:0] app_ms;
  } limits_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dmhc_if.sv
// ============================================================================
// dmhc_if
// Item channels of the display mode history controller.
// ============================================================================
`default_nettype none

interface dmhc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [2:0]  target_mode;
  logic [7:0]  app_number;
  logic [31:0] time_ms;
  logic        to_menu;

  modport source (output valid, opcode, target_mode, app_number, time_ms, to_menu,
                  input ready);
  modport sink   (input valid, opcode, target_mode, app_number, time_ms, to_menu,
                  output ready);
endinterface

interface dmhc_out_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic       timed_out;
  logic [2:0] mode_now;
  logic [3:0] history_count;
  logic       transition_event;
  logic       power_event;

  modport source (output valid, ok, timed_out, mode_now, history_count,
                  transition_event, power_event, input ready);
  modport sink   (input valid, ok, timed_out, mode_now, history_count,
                  transition_event, power_event, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/display_mode_history_controller.sv
// ============================================================================
// display_mode_history_controller
// Display mode tracker with a bounded (mode, app id) history stack.
// ============================================================================
// Result: the item is registered on accept and the result is registered on
//   commit, which waits while an earlier result still waits at the output.
// Items: a new item is taken only once the previous one has committed; the
//   stack memory read is issued on accept and the write-back made on commit.
// An item is accepted while an earlier result still waits at the output.
// Reset: synchronous, active low; mode idle, one idle entry on the stack,
//   limits at 30000 / 60000 / 120000 ms; no memory clearing pass.
`default_nettype none

module display_mode_history_controller
  import dmhc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  dmhc_in_if.sink                    in_item,
  dmhc_out_if.source                 out_item,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output      logic [31:0]           cfg_prdata,
  output      logic                  cfg_pready
);

  limits_t     limits;
  hist_req_t   mem_req;
  hist_entry_t mem_rd;

  dmhc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .limits  (limits)
  );

  dmhc_hist_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

  dmhc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_item),
    .out_ch  (out_item),
    .limits  (limits),
    .mem_req (mem_req),
    .mem_rd  (mem_rd)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_item.ready) |=> !in_item.ready)
    else $error("item accepted while another is in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid |-> (out_item.history_count <= COUNT_OUT_W'(HIST_DEPTH)))
    else $error("history count beyond stack depth");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid |-> (out_item.mode_now <= M_OFF))
    else $error("illegal mode reported");

  a_timeout_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && out_item.timed_out) |-> out_item.ok)
    else $error("timeout without ok");

  a_no_wr_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.rd_en |-> !mem_req.wr_en)
    else $error("stack read and write in the same cycle");

endmodule

`default_nettype wire

FILE: hw/rtl/dmhc_cfg_regs.sv
// ============================================================================
// dmhc_cfg_regs
// APB-style register block holding the three inactivity limits.
// ============================================================================
`default_nettype none

module dmhc_cfg_regs
  import dmhc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output      logic [31:0]           prdata,
  output      logic                  pready,
  output      limits_t               limits
);

  limits_t     lim_r;
  limits_t     lim_nxt;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign limits  = lim_r;

  always_comb begin
    lim_nxt = lim_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_IDLE_LIMIT: lim_nxt.idle_ms = pwdata;
        REG_MENU_LIMIT: lim_nxt.menu_ms = pwdata;
        REG_APP_LIMIT:  lim_nxt.app_ms  = pwdata;
        default:        lim_nxt = lim_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IDLE_LIMIT: prdata = lim_r.idle_ms;
      REG_MENU_LIMIT: prdata = lim_r.menu_ms;
      REG_APP_LIMIT:  prdata = lim_r.app_ms;
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.idle_ms <= IDLE_LIMIT_RST;
      lim_r.menu_ms <= MENU_LIMIT_RST;
      lim_r.app_ms  <= APP_LIMIT_RST;
    end else begin
      lim_r <= lim_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dmhc_hist_mem.sv
// ============================================================================
// dmhc_hist_mem
// History stack storage: one write and one registered read per cycle.
// ============================================================================
`default_nettype none

module dmhc_hist_mem
  import dmhc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire hist_req_t   req,
  output      hist_entry_t rd_data
);

  hist_entry_t mem [HIST_DEPTH];
  hist_entry_t rd_q_r;
  logic        rd_blank_r;
  logic        ent0_vld_r;

  // entry 0 reads as idle / zero until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent0_vld_r <= 1'b0;
    end else if (req.wr_en && req.wr_addr == '0) begin
      ent0_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_q_r     <= mem[req.rd_addr];
      rd_blank_r <= (req.rd_addr == '0) && !ent0_vld_r;
    end
  end

  assign rd_data = rd_blank_r ? hist_entry_t'('0) : rd_q_r;

endmodule

`default_nettype wire

FILE: hw/rtl/dmhc_core.sv
// ============================================================================
// dmhc_core
// Mode sequencer: reads the stack top, applies one operation, writes any push.
// ============================================================================
`default_nettype none

module dmhc_core
  import dmhc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  dmhc_in_if.sink          in_ch,
  dmhc_out_if.source       out_ch,
  input  wire limits_t     limits,
  output      hist_req_t   mem_req,
  input  wire hist_entry_t mem_rd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic [2:0]            mode_r, mode_nxt;
  logic                  act_r, act_nxt;
  logic [31:0]           last_r, last_nxt;
  logic [HIST_PTR_W-1:0] top_r, top_nxt;
  logic [HIST_CNT_W-1:0] cnt_r, cnt_nxt;

  logic [2:0]            op_r;
  logic [2:0]            tgt_r;
  logic [7:0]            app_r;
  logic [31:0]           time_r;
  logic                  menu_r;

  logic                  out_vld_r, out_vld_nxt;
  logic                  ok_r, tmo_r, evt_r, evp_r;
  logic                  ok_c, tmo_c, evt_c, evp_c;

  logic                  accept;
  logic                  commit;
  logic [HIST_PTR_W-1:0] pop_pos;
  logic [HIST_PTR_W-1:0] top_inc;
  logic [HIST_CNT_W-1:0] cnt_inc;
  logic                  can_pop;
  logic [31:0]           lim;
  logic [31:0]           elapsed;

  logic                  do_trans;
  logic                  popped;
  logic [2:0]            tr_tgt;
  logic [7:0]            tr_app;
  logic                  wr_en_c;
  logic [HIST_PTR_W-1:0] wr_addr_c;
  hist_entry_t           wr_data_c;

  assign accept  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign commit  = (state_r == S_EXEC) && (!out_vld_r || out_ch.ready);

  assign pop_pos = (top_r == '0) ? PTR_LAST : top_r - 1'b1;
  assign top_inc = (top_r == PTR_LAST) ? '0 : top_r + 1'b1;
  assign cnt_inc = (cnt_r == CNT_FULL) ? cnt_r : cnt_r + 1'b1;
  assign can_pop = (cnt_r != '0);
  assign elapsed = time_r - last_r;

  always_comb begin
    priority if (mode_r == M_MENU) begin
      lim = limits.menu_ms;
    end else if (mode_r == M_APP) begin
      lim = limits.app_ms;
    end else begin
      lim = limits.idle_ms;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    act_nxt   = act_r;
    last_nxt  = last_r;
    top_nxt   = top_r;
    cnt_nxt   = cnt_r;
    ok_c      = 1'b0;
    tmo_c     = 1'b0;
    evt_c     = 1'b0;
    evp_c     = 1'b0;
    do_trans  = 1'b0;
    popped    = 1'b0;
    tr_tgt    = M_IDLE;
    tr_app    = 8'd0;
    wr_en_c   = 1'b0;
    wr_addr_c = top_r;
    wr_data_c = hist_entry_t'('0);

    unique case (op_r)
      OP_TRANS: begin
        do_trans = 1'b1;
        tr_tgt   = tgt_r;
        tr_app   = app_r;
      end
      OP_BACK: begin
        if (!can_pop) begin
          mode_nxt = M_IDLE;
        end else if (mem_rd.mode != mode_r) begin
          popped   = 1'b1;
          do_trans = 1'b1;
          tr_tgt   = mem_rd.mode;
          tr_app   = mem_rd.app;
        end
      end
      OP_ACTIVITY: begin
        act_nxt  = 1'b1;
        last_nxt = time_r;
        ok_c     = 1'b1;
      end
      OP_CHECK: begin
        tmo_c = !act_r || (elapsed > lim);
        ok_c  = tmo_c;
      end
      OP_LOWPOWER, OP_SHUTDOWN: begin
        if (mode_r == M_MENU || mode_r == M_APP || mode_r == M_NESTED) begin
          wr_en_c   = 1'b1;
          wr_addr_c = top_r;
          wr_data_c = '{mode: mode_r, app: 8'd0};
          top_nxt   = top_inc;
          cnt_nxt   = cnt_inc;
        end
        mode_nxt = (op_r == OP_LOWPOWER) ? M_LOWPOWER : M_OFF;
        act_nxt  = 1'b0;
        evp_c    = 1'b1;
        ok_c     = 1'b1;
      end
      OP_WAKE: begin
        do_trans = 1'b1;
        if (menu_r) begin
          tr_tgt = M_MENU;
        end else if (can_pop) begin
          popped = 1'b1;
          tr_tgt = mem_rd.mode;
        end else begin
          tr_tgt = M_IDLE;
        end
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase

    if (popped) begin
      top_nxt = pop_pos;
      cnt_nxt = cnt_r - 1'b1;
    end

    if (do_trans) begin
      if (tr_tgt > M_OFF) begin
        ok_c = 1'b0;
      end else if (tr_tgt == mode_r && mode_r != M_NESTED) begin
        ok_c = 1'b1;
      end else begin
        mode_nxt = tr_tgt;
        act_nxt  = 1'b1;
        evt_c    = 1'b1;
        ok_c     = 1'b1;
        if (tr_tgt == M_NESTED) begin
          // push back into the slot just popped, or onto the top
          wr_en_c        = 1'b1;
          wr_addr_c      = popped ? pop_pos : top_r;
          wr_data_c.mode = mode_r;
          wr_data_c.app  = (mode_r == M_APP) ? tr_app : 8'd0;
          top_nxt        = popped ? top_r : top_inc;
          cnt_nxt        = popped ? cnt_r : cnt_inc;
        end
      end
    end
  end

  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = commit ? S_IDLE : S_EXEC;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_vld_nxt = commit || (out_vld_r && !out_ch.ready);

  assign mem_req.rd_en   = accept;
  assign mem_req.rd_addr = pop_pos;
  assign mem_req.wr_en   = commit && wr_en_c;
  assign mem_req.wr_addr = wr_addr_c;
  assign mem_req.wr_data = wr_data_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mode_r    <= M_IDLE;
      act_r     <= 1'b1;
      last_r    <= 32'd0;
      top_r     <= HIST_PTR_W'(1);
      cnt_r     <= HIST_CNT_W'(1);
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      if (commit) begin
        mode_r <= mode_nxt;
        act_r  <= act_nxt;
        last_r <= last_nxt;
        top_r  <= top_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_ch.opcode;
      tgt_r  <= in_ch.target_mode;
      app_r  <= in_ch.app_number;
      time_r <= in_ch.time_ms;
      menu_r <= in_ch.to_menu;
    end
    if (commit) begin
      ok_r  <= ok_c;
      tmo_r <= tmo_c;
      evt_r <= evt_c;
      evp_r <= evp_c;
    end
  end

  logic [2:0]             mode_out_r;
  logic [COUNT_OUT_W-1:0] cnt_out_r;

  always_ff @(posedge clk) begin
    if (commit) begin
      mode_out_r <= mode_nxt;
      cnt_out_r  <= COUNT_OUT_W'(cnt_nxt);
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.ok               = ok_r;
  assign out_ch.timed_out        = tmo_r;
  assign out_ch.mode_now         = mode_out_r;
  assign out_ch.history_count    = cnt_out_r;
  assign out_ch.transition_event = evt_r;
  assign out_ch.power_event      = evp_r;

endmodule

`default_nettype wire

FILE: sim/display_mode_history_controller_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// display_mode_history_controller_tb
// Drives mode commands through the item channel, tracks the expected mode,
// history stack and inactivity state alongside, and checks every status item.
// Limits are reprogrammed between drained phases, with back-pressure varied.
// ============================================================================

module display_mode_history_controller_tb;
  import dmhc_pkg::*;

  localparam logic [2:0] OP_INVALID   = 3'd7;
  localparam logic [2:0] M_RSVD_A     = 3'd6;
  localparam logic [2:0] M_RSVD_B     = 3'd7;
  localparam int         LIMIT_CYCLES = 200000;
  localparam int         LONG_HOLD    = 300;
  localparam int         PHASE_ITEMS  = 350;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  target_mode;
    logic [7:0]  app_number;
    logic [31:0] time_ms;
    logic        to_menu;
  } ui_cmd_t;

  typedef struct packed {
    logic       ok;
    logic       timed_out;
    logic [2:0] mode_now;
    logic [3:0] history_count;
    logic       transition_event;
    logic       power_event;
  } mode_status_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  dmhc_in_if  cmd_ch ();
  dmhc_out_if status_ch ();

  display_mode_history_controller DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (cmd_ch),
    .out_item    (status_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  ui_cmd_t      pending_cmds[$];
  mode_status_t expected_status[$];
  ui_cmd_t      on_wire;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           mismatches;
  int           cycles;
  bit           hold_toggle;
  bit           hold_seen;
  int           hold_left;

  // mirrored controller state
  logic [2:0]  cur_mode;
  logic        act_valid;
  logic [31:0] act_stamp;
  logic [2:0]  hist_mode[HIST_DEPTH];
  logic [7:0]  hist_app[HIST_DEPTH];
  int          hist_wr;
  int          hist_fill;
  logic [31:0] lim_idle;
  logic [31:0] lim_menu;
  logic [31:0] lim_app;
  logic        ev_trans;
  logic        ev_pwr;

  // stimulus-side view of time and limits
  logic [31:0] stim_clock;
  logic [31:0] stim_last_act;
  logic [31:0] stim_lim[3];

  function automatic void reset_model();
    cur_mode  = M_IDLE;
    act_valid = 1'b1;
    act_stamp = '0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_mode[i] = M_IDLE;
      hist_app[i]  = '0;
    end
    hist_wr   = 1;
    hist_fill = 1;
    lim_idle  = IDLE_LIMIT_RST;
    lim_menu  = MENU_LIMIT_RST;
    lim_app   = APP_LIMIT_RST;
  endfunction

  function automatic void hist_store(logic [2:0] m, logic [7:0] a);
    if (hist_wr >= HIST_DEPTH) hist_wr = 0;
    hist_mode[hist_wr] = m;
    hist_app[hist_wr]  = a;
    hist_wr = (hist_wr + 1 >= HIST_DEPTH) ? 0 : hist_wr + 1;
    if (hist_fill < HIST_DEPTH) hist_fill++;
  endfunction

  function automatic bit hist_take(output logic [2:0] m, output logic [7:0] a);
    int pos;
    m = M_IDLE;
    a = '0;
    if (hist_fill == 0) return 1'b0;
    pos = (hist_wr == 0) ? HIST_DEPTH - 1 : hist_wr - 1;
    m = hist_mode[pos];
    a = hist_app[pos];
    hist_wr = pos;
    hist_fill--;
    return 1'b1;
  endfunction

  function automatic bit enter_mode(logic [2:0] target, logic [7:0] app);
    logic [2:0] prev;
    prev = cur_mode;
    if (target > M_OFF) return 1'b0;
    if (target == prev && prev != M_NESTED) return 1'b1;
    cur_mode  = target;
    act_valid = 1'b1;
    if (target == M_NESTED) hist_store(prev, (prev == M_APP) ? app : 8'h00);
    ev_trans = 1'b1;
    return 1'b1;
  endfunction

  function automatic void sleep_to(logic [2:0] target);
    if (cur_mode != M_IDLE && cur_mode != M_LOWPOWER && cur_mode != M_OFF)
      hist_store(cur_mode, 8'h00);
    cur_mode  = target;
    act_valid = 1'b0;
    ev_pwr    = 1'b1;
  endfunction

  function automatic mode_status_t predict_status(ui_cmd_t c);
    mode_status_t r;
    logic [2:0]   pm;
    logic [7:0]   pa;
    logic [31:0]  lim;
    logic         ok;
    logic         tmo;
    ok       = 1'b0;
    tmo      = 1'b0;
    ev_trans = 1'b0;
    ev_pwr   = 1'b0;
    case (c.opcode)
      OP_TRANS: ok = enter_mode(c.target_mode, c.app_number);
      OP_BACK: begin
        if (!hist_take(pm, pa)) cur_mode = M_IDLE;
        else if (pm == cur_mode) hist_store(pm, pa);
        else ok = enter_mode(pm, pa);
      end
      OP_ACTIVITY: begin
        act_valid = 1'b1;
        act_stamp = c.time_ms;
        ok        = 1'b1;
      end
      OP_CHECK: begin
        if (!act_valid) begin
          tmo = 1'b1;
        end else begin
          lim = (cur_mode == M_MENU) ? lim_menu : (cur_mode == M_APP) ? lim_app : lim_idle;
          tmo = (c.time_ms - act_stamp) > lim;
        end
        ok = tmo;
      end
      OP_LOWPOWER: begin
        sleep_to(M_LOWPOWER);
        ok = 1'b1;
      end
      OP_WAKE: begin
        if (c.to_menu) pm = M_MENU;
        else if (!hist_take(pm, pa)) pm = M_IDLE;
        ok = enter_mode(pm, 8'h00);
      end
      OP_SHUTDOWN: begin
        sleep_to(M_OFF);
        ok = 1'b1;
      end
      default: ok = 1'b0;
    endcase
    r.ok               = ok;
    r.timed_out        = tmo;
    r.mode_now         = cur_mode;
    r.history_count    = hist_fill[3:0];
    r.transition_event = ev_trans;
    r.power_event      = ev_pwr;
    return r;
  endfunction

  function automatic ui_cmd_t cmd(logic [2:0] op, logic [2:0] target, logic [7:0] app,
                                  logic [31:0] t, logic menu);
    ui_cmd_t c;
    c.opcode      = op;
    c.target_mode = target;
    c.app_number  = app;
    c.time_ms     = t;
    c.to_menu     = menu;
    return c;
  endfunction

  function automatic ui_cmd_t random_cmd();
    ui_cmd_t     c;
    int          pick;
    logic [31:0] lim;
    c.opcode      = 3'($urandom_range(6));
    c.target_mode = 3'($urandom_range(7));
    c.app_number  = 8'($urandom);
    c.time_ms     = $urandom;
    c.to_menu     = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 34) begin
      c.opcode = OP_TRANS;
      if ($urandom_range(99) >= 4) c.target_mode = 3'($urandom_range(M_OFF));
      if ($urandom_range(3) == 0) c.target_mode = M_NESTED;
    end else if (pick < 50) begin
      c.opcode = OP_BACK;
    end else if (pick < 62) begin
      c.opcode = OP_ACTIVITY;
      if ($urandom_range(9) != 0) begin
        stim_clock = stim_clock + $urandom_range(40000);
        c.time_ms  = stim_clock;
      end
      stim_last_act = c.time_ms;
    end else if (pick < 80) begin
      c.opcode = OP_CHECK;
      lim = stim_lim[$urandom_range(2)];
      case ($urandom_range(4))
        0: c.time_ms = stim_last_act + lim;
        1: c.time_ms = stim_last_act + lim + 1;
        2: c.time_ms = stim_last_act + lim - 1;
        3: c.time_ms = stim_last_act + $urandom_range(200000);
        default: ;
      endcase
    end else if (pick < 86) begin
      c.opcode = OP_LOWPOWER;
    end else if (pick < 93) begin
      c.opcode = OP_WAKE;
    end else if (pick < 97) begin
      c.opcode = OP_SHUTDOWN;
    end else begin
      c.opcode = OP_INVALID;
    end
    return c;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    check_field($sformatf("cfg reg %0d", idx), val, cfg_prdata);
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_limits(logic [31:0] idle_v, logic [31:0] menu_v, logic [31:0] app_v);
    cfg_write(REG_IDLE_LIMIT, idle_v);
    cfg_write(REG_MENU_LIMIT, menu_v);
    cfg_write(REG_APP_LIMIT, app_v);
    lim_idle = idle_v;
    lim_menu = menu_v;
    lim_app  = app_v;
    stim_lim[0] = idle_v;
    stim_lim[1] = menu_v;
    stim_lim[2] = app_v;
  endtask

  // sample away from the driving edge so the queues and valid have settled
  task automatic wait_drain();
    while (pending_cmds.size() != 0 || cmd_ch.valid || expected_status.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int n, int s_idle, int r_stall, bit long_hold);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    for (int i = 0; i < n; i++) pending_cmds.push_back(random_cmd());
    if (long_hold) hold_toggle = ~hold_toggle;
    wait_drain();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // offer the next command; hold it until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) expected_status.push_back(predict_status(on_wire));
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = pending_cmds.pop_front();
          cmd_ch.valid       <= 1'b1;
          cmd_ch.opcode      <= on_wire.opcode;
          cmd_ch.target_mode <= on_wire.target_mode;
          cmd_ch.app_number  <= on_wire.app_number;
          cmd_ch.time_ms     <= on_wire.time_ms;
          cmd_ch.to_menu     <= on_wire.to_menu;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    mode_status_t exp_s;
    if (!rst_n) begin
      status_ch.ready <= 1'b0;
    end else begin
      if (status_ch.valid && status_ch.ready) begin
        if (expected_status.size() == 0) begin
          $error("status item with nothing expected");
          mismatches++;
        end else begin
          exp_s = expected_status.pop_front();
          check_field("ok", exp_s.ok, status_ch.ok);
          check_field("timed_out", exp_s.timed_out, status_ch.timed_out);
          check_field("mode_now", exp_s.mode_now, status_ch.mode_now);
          check_field("history_count", exp_s.history_count, status_ch.history_count);
          check_field("transition_event", exp_s.transition_event, status_ch.transition_event);
          check_field("power_event", exp_s.power_event, status_ch.power_event);
        end
      end
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        status_ch.ready <= 1'b0;
      end else begin
        status_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    reset_model();
    stim_clock    = '0;
    stim_last_act = '0;
    stim_lim[0]   = IDLE_LIMIT_RST;
    stim_lim[1]   = MENU_LIMIT_RST;
    stim_lim[2]   = APP_LIMIT_RST;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches  = 0;
    cycles      = 0;
    hold_toggle = 1'b0;
    hold_seen   = 1'b0;
    hold_left   = 0;
    rst_n       = 1'b0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.opcode      = OP_TRANS;
    cmd_ch.target_mode = M_IDLE;
    cmd_ch.app_number  = '0;
    cmd_ch.time_ms     = '0;
    cmd_ch.to_menu     = 1'b0;
    status_ch.ready    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pending_cmds.push_back(cmd(OP_CHECK, M_IDLE, 8'h00, 32'd30000, 1'b0));
    pending_cmds.push_back(cmd(OP_CHECK, M_IDLE, 8'h00, 32'd30001, 1'b0));
    pending_cmds.push_back(cmd(OP_BACK, M_IDLE, 8'h00, 32'h0, 1'b0));
    pending_cmds.push_back(cmd(OP_TRANS, M_MENU, 8'hFF, 32'h0, 1'b1));
    pending_cmds.push_back(cmd(OP_TRANS, M_MENU, 8'h00, 32'h0, 1'b0));
    pending_cmds.push_back(cmd(OP_TRANS, M_APP, 8'hAA, 32'h0, 1'b0));
    pending_cmds.push_back(cmd(OP_TRANS, M_NESTED, 8'h5A, 32'h0, 1'b0));
    pending_cmds.push_back(cmd(OP_TRANS, M_NESTED, 8'hFF, 32'h0, 1'b0));
    pending_cmds.push_back(cmd(OP_BACK, M_IDLE, 8'h00, 32'h0, 1'b0));
    pending_cmds.push_back(cmd(OP_ACTIVITY, M_IDLE, 8'h00, 32'hFFFF_FFFF, 1'b0));
    pending_cmds.push_back(cmd(OP_CHECK, M_IDLE, 8'h00, 32'h0, 1'b0));
    pending_cmds.push_back(cmd(OP_TRANS, M_RSVD_A, 8'h11, 32'h0, 1'b0));
    pending_cmds.push_back(cmd(OP_TRANS, M_RSVD_B, 8'h22, 32'h0, 1'b0));
    pending_cmds.push_back(cmd(OP_INVALID, M_MENU, 8'h33, 32'hFFFF_FFFF, 1'b1));
    pending_cmds.push_back(cmd(OP_LOWPOWER, M_IDLE, 8'h00, 32'h0, 1'b0));
    pending_cmds.push_back(cmd(OP_CHECK, M_IDLE, 8'h00, 32'hFFFF_FFFF, 1'b0));
    pending_cmds.push_back(cmd(OP_WAKE, M_IDLE, 8'h00, 32'h0, 1'b0));
    pending_cmds.push_back(cmd(OP_SHUTDOWN, M_IDLE, 8'h00, 32'h0, 1'b0));
    pending_cmds.push_back(cmd(OP_WAKE, M_IDLE, 8'h00, 32'h0, 1'b1));
    pending_cmds.push_back(cmd(OP_TRANS, M_OFF, 8'h00, 32'h0, 1'b0));
    for (int i = 0; i < 5; i++)
      pending_cmds.push_back(cmd(OP_BACK, M_IDLE, 8'h00, 32'h0, 1'b0));
    stim_last_act = 32'hFFFF_FFFF;

    run_phase(PHASE_ITEMS, 8, 66, 1'b0);
    set_limits('0, '0, '0);
    run_phase(PHASE_ITEMS, 8, 66, 1'b0);
    set_limits('1, '1, '1);
    run_phase(PHASE_ITEMS, 66, 8, 1'b0);
    set_limits($urandom_range(200000), $urandom_range(200000), $urandom_range(200000));
    run_phase(PHASE_ITEMS, 66, 8, 1'b0);
    set_limits(32'd1, '1, $urandom);
    run_phase(PHASE_ITEMS, 0, 0, 1'b1);

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/dmhc_pkg.sv
hw/rtl/dmhc_if.sv
hw/rtl/dmhc_cfg_regs.sv
hw/rtl/dmhc_hist_mem.sv
hw/rtl/dmhc_core.sv
hw/rtl/display_mode_history_controller.sv
sim/display_mode_history_controller_tb.sv
